// File: rtl/trms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trms_pkg
// Shared types and codes for the token-ring MAC sender.
// ----------------------------------------------------------------------------
package trms_pkg;

  // input action codes
  localparam logic [2:0] ACT_NEW_TOKEN  = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_STOP       = 3'd2;
  localparam logic [2:0] ACT_MSG_BYTE   = 3'd3;
  localparam logic [2:0] ACT_TOKEN_BYTE = 3'd4;
  localparam logic [2:0] ACT_STATUS     = 3'd5;

  // result targets
  localparam logic [1:0] TGT_PHY  = 2'd0;
  localparam logic [1:0] TGT_LIST = 2'd1;
  localparam logic [1:0] TGT_ERR  = 2'd2;

  // error kinds
  localparam logic ERR_CHECKSUM  = 1'b0;
  localparam logic ERR_NO_ANSWER = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_OWN_ADDRESS       = 3'd0;
  localparam logic [2:0] CFG_TOKEN_TAG_VALUE   = 3'd1;
  localparam logic [2:0] CFG_TIME_SERVICE      = 3'd2;
  localparam logic [2:0] CFG_CHAT_SERVICE      = 3'd3;
  localparam logic [2:0] CFG_BROADCAST_STATION = 3'd4;

  // message write mask bits
  localparam int MW_H0   = 0;
  localparam int MW_H1   = 1;
  localparam int MW_PAY  = 2;
  localparam int MW_LEN  = 3;
  localparam int MW_STAT = 4;

  localparam int CMD_FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NEW_TOKEN,
    OP_START,
    OP_STOP,
    OP_MSG,
    OP_TOKEN,
    OP_STATUS
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] dst;
    logic [2:0] dsap;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] own;
    logic [7:0] tag;
    logic [2:0] tsap;
    logic [2:0] csap;
    logic [3:0] bcast;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_TOKEN,
    ST_MSG_WR,
    ST_TOK_ZERO,
    ST_TOK_DECIDE,
    ST_TOK_OWN,
    ST_TOK_CMP,
    ST_TOK_CHG,
    ST_TOK_SEND,
    ST_FRM_RD,
    ST_FRM_EMIT,
    ST_RES_RD,
    ST_RES_EMIT,
    ST_ERR
  } state_t;

endpackage

// File: rtl/token_ring_mac_sender_core.sv
`timescale 1ns / 1ps
// A queued command is taken only while the back end is idle; its work starts in the next cycle.
// Message byte: up to five frame memory writes, one write per cycle.
// Token and new token bursts: one byte per cycle unless the output stalls; frame
// send and resend: each byte is read into a register from memory, then emitted.
// Reset (rst_n, synchronous) clears control state and the known list;
// frame and token storage are not cleared.
// ----------------------------------------------------------------------------
// token_ring_mac_sender_core
// Token-ring MAC sender: frame builder, frame queue and token handling.
// ----------------------------------------------------------------------------
module token_ring_mac_sender_core #(
  parameter int STATIONS    = 15,
  parameter int MAX_FRAME   = 50,
  parameter int QUEUE_DEPTH = 3,
  parameter int MAX_RETRIES = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [3:0] in_dest_station,
  input  logic [2:0] in_dest_service,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_target,
  output logic [7:0] out_out_byte,
  output logic       out_error_kind,
  output logic [3:0] out_error_station,
  output logic       out_end_of_run
);
  import trms_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{own: 4'd0, tag: 8'd255, tsap: 3'd1, csap: 3'd3, bcast: 4'd15};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:       cfg_r.own   <= cfg_wdata[3:0];
        CFG_TOKEN_TAG_VALUE:   cfg_r.tag   <= cfg_wdata;
        CFG_TIME_SERVICE:      cfg_r.tsap  <= cfg_wdata[2:0];
        CFG_CHAT_SERVICE:      cfg_r.csap  <= cfg_wdata[2:0];
        CFG_BROADCAST_STATION: cfg_r.bcast <= cfg_wdata[3:0];
        default:               cfg_r <= cfg_r;
      endcase
    end
  end

  trms_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_dest_station (in_dest_station),
    .in_dest_service (in_dest_service),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop)
  );

  trms_back #(
    .STATIONS    (STATIONS),
    .MAX_FRAME   (MAX_FRAME),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_target        (out_target),
    .out_out_byte      (out_out_byte),
    .out_error_kind    (out_error_kind),
    .out_error_station (out_error_station),
    .out_end_of_run    (out_end_of_run)
  );

endmodule

// File: rtl/trms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trms_front
// Accepts input transactions, classifies the action and queues commands.
// ----------------------------------------------------------------------------
module trms_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     in_action,
  input  logic [3:0]     in_dest_station,
  input  logic [2:0]     in_dest_service,
  input  logic [7:0]     in_data_byte,
  input  logic           in_last_byte,
  output trms_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_pop
);
  import trms_pkg::*;

  localparam int PW = $clog2(CMD_FIFO_DEPTH);
  localparam int CNTW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            fifo_r [CMD_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            op_ok;
  op_t             op;
  logic            push;

  always_comb begin
    op_ok = 1'b1;
    op    = OP_START;
    case (in_action)
      ACT_NEW_TOKEN:  op = OP_NEW_TOKEN;
      ACT_START:      op = OP_START;
      ACT_STOP:       op = OP_STOP;
      ACT_MSG_BYTE:   op = OP_MSG;
      ACT_TOKEN_BYTE: op = OP_TOKEN;
      ACT_STATUS:     op = OP_STATUS;
      default:        op_ok = 1'b0;  // unused actions are taken and dropped
    endcase
  end

  assign in_stall  = (cnt_r == CNTW'(CMD_FIFO_DEPTH));
  assign push      = in_valid && !in_stall && op_ok;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{op: op, dst: in_dest_station, dsap: in_dest_service,
                            data: in_data_byte, last: in_last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (cmd_pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      case ({push, cmd_pop})
        2'b10:   cnt_r <= cnt_r + CNTW'(1);
        2'b01:   cnt_r <= cnt_r - CNTW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/trms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trms_back
// Executes queued commands: frame building, token handling, frame send,
// resend and error reporting, with a registered result stage.
// ----------------------------------------------------------------------------
module trms_back #(
  parameter int STATIONS    = 15,
  parameter int MAX_FRAME   = 50,
  parameter int QUEUE_DEPTH = 3,
  parameter int MAX_RETRIES = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  trms_pkg::cfg_t cfg,
  input  trms_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_target,
  output logic [7:0]     out_out_byte,
  output logic           out_error_kind,
  output logic [3:0]     out_error_station,
  output logic           out_end_of_run
);
  import trms_pkg::*;

  localparam int TLEN = STATIONS + 1;
  localparam int MAXP = MAX_FRAME - 4;
  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TSW  = QAW + 2;
  localparam int FAW  = $clog2(QUEUE_DEPTH * MAX_FRAME);
  localparam int SAW  = $clog2(MAX_FRAME);
  localparam int CW   = $clog2(MAX_FRAME);
  localparam int LW   = $clog2(MAX_FRAME + 1);
  localparam int TCW  = $clog2(TLEN + 1);
  localparam int TIW  = $clog2(TLEN);
  localparam int SIW  = $clog2(STATIONS);
  localparam int IW   = $clog2(((MAX_FRAME > TLEN) ? MAX_FRAME : TLEN) + 1);
  localparam int RW   = (MAX_RETRIES > 0) ? $clog2(MAX_RETRIES + 1) : 1;

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r;

  // frame storage
  logic [7:0]     fq_mem [QUEUE_DEPTH * MAX_FRAME];
  logic [7:0]     fq_rd_r;
  logic [7:0]     sent_mem [MAX_FRAME];
  logic [7:0]     sent_rd_r;
  logic           fq_we;
  logic [FAW-1:0] fq_wa;
  logic [7:0]     fq_wd;

  logic [LW-1:0]  qlen_r [QUEUE_DEPTH];
  logic [QAW-1:0] q_head_r;
  logic [QCW-1:0] q_count_r;
  logic [CW-1:0]  b_count_r;
  logic [5:0]     b_sum_r;
  logic           b_drop_r;

  logic [4:0]     wr_mask_r;
  logic [FAW-1:0] wr_base_r;
  logic [7:0]     wr_h0_r, wr_h1_r, wr_data_r, wr_stat_r;
  logic [CW-1:0]  wr_pcnt_r, wr_cnt_r;

  logic [LW-1:0]  sent_len_r;
  logic [3:0]     sent_dst_r;
  logic [FAW-1:0] rd_base_r;

  logic [7:0]     held_r [TLEN];
  logic [TCW-1:0] tok_cnt_r;
  logic           tok_held_r;
  logic [7:0]     known_r [STATIONS];
  logic           conn_r, chg_r;
  logic [RW-1:0]  retry_r;
  logic           err_kind_r;

  // result register
  logic       out_valid_r;
  logic [1:0] out_target_r;
  logic [7:0] out_byte_r;
  logic       out_kind_r;
  logic [3:0] out_station_r;
  logic       out_end_r;

  // combinational helpers
  logic           out_free;
  logic [7:0]     both, time_only;
  logic [TSW-1:0] tail_sum, tail_wrap;
  logic [QAW-1:0] tail_idx;
  logic [FAW-1:0] tail_base;
  logic           first;
  logic [2:0]     ssap;
  logic [7:0]     h0, h1;
  logic [5:0]     s0, s1, stat_sum;
  logic           pay_ok;
  logic [CW-1:0]  cnt1;
  logic           drop;
  logic [4:0]     mask;
  logic           tc_ok;
  logic [TCW-1:0] tcnt1;
  logic           retry_ok;
  logic [4:0]     mask_rest;
  logic [SIW-1:0] st_idx;
  logic           cmp_diff, chg_now;
  logic [IW-1:0]  frame_last;

  // emission
  logic       emit;
  logic [1:0] e_target;
  logic [7:0] e_byte;
  logic       e_kind;
  logic [3:0] e_station;
  logic       e_end;

  assign out_free  = !out_valid_r || !out_stall;
  assign both      = (8'd1 << cfg.tsap) | (8'd1 << cfg.csap);
  assign time_only = 8'd1 << cfg.tsap;

  assign tail_sum  = TSW'(q_head_r) + TSW'(q_count_r);
  assign tail_wrap = (tail_sum >= TSW'(QUEUE_DEPTH)) ? tail_sum - TSW'(QUEUE_DEPTH) : tail_sum;
  assign tail_idx  = QAW'(tail_wrap);
  assign tail_base = FAW'(32'(tail_idx) * MAX_FRAME);

  assign first    = (b_count_r == '0);
  assign ssap     = (cmd.dst == cfg.bcast) ? cfg.tsap : cfg.csap;
  assign h0       = {1'b0, cfg.own, ssap};
  assign h1       = {1'b0, cmd.dst, cmd.dsap};
  assign s0       = first ? (h0[5:0] + h1[5:0]) : b_sum_r;
  assign pay_ok   = (b_count_r < CW'(MAXP));
  assign s1       = pay_ok ? (s0 + cmd.data[5:0]) : s0;
  assign cnt1     = pay_ok ? (b_count_r + CW'(1)) : b_count_r;
  assign drop     = first ? (q_count_r >= QCW'(QUEUE_DEPTH)) : b_drop_r;
  assign stat_sum = s1 + 6'(cnt1);

  always_comb begin
    mask = '0;
    if (!drop) begin
      mask[MW_H0]   = first;
      mask[MW_H1]   = first;
      mask[MW_PAY]  = pay_ok;
      mask[MW_LEN]  = cmd.last;
      mask[MW_STAT] = cmd.last;
    end
  end

  assign tc_ok     = (tok_cnt_r < TCW'(TLEN));
  assign tcnt1     = tc_ok ? (tok_cnt_r + TCW'(1)) : tok_cnt_r;
  assign retry_ok  = (retry_r < RW'(MAX_RETRIES));
  assign mask_rest = wr_mask_r & (wr_mask_r - 5'd1);
  assign st_idx    = SIW'(idx_r);
  assign cmp_diff  = (known_r[st_idx] != held_r[TIW'(idx_r + IW'(1))]);
  assign chg_now   = chg_r || cmp_diff;
  assign frame_last = IW'(sent_len_r) - IW'(1);

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_NEW_TOKEN: state_nxt = ST_NEW_TOKEN;
            OP_MSG:       state_nxt = (mask != '0) ? ST_MSG_WR : ST_IDLE;
            OP_TOKEN:     state_nxt = (!tok_held_r && cmd.last) ? ST_TOK_ZERO : ST_IDLE;
            OP_STATUS: begin
              if (tok_held_r) begin
                if (cmd.data[1:0] == 2'b11) state_nxt = ST_TOK_SEND;
                else if (cmd.data[1]) state_nxt = retry_ok ? ST_RES_RD : ST_ERR;
                else state_nxt = ST_ERR;
              end
            end
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NEW_TOKEN:  if (emit && e_end) state_nxt = ST_IDLE;
      ST_MSG_WR:     if (mask_rest == '0) state_nxt = ST_IDLE;
      ST_TOK_ZERO:   if (idx_r >= IW'(TLEN)) state_nxt = ST_TOK_DECIDE;
      ST_TOK_DECIDE: state_nxt = (q_count_r != '0) ? ST_FRM_RD : ST_TOK_OWN;
      ST_TOK_OWN:    state_nxt = ST_TOK_CMP;
      ST_TOK_CMP: begin
        if (idx_r == IW'(STATIONS - 1)) state_nxt = chg_now ? ST_TOK_CHG : ST_TOK_SEND;
      end
      ST_TOK_CHG:    if (emit) state_nxt = ST_TOK_SEND;
      ST_TOK_SEND:   if (emit && e_end) state_nxt = ST_IDLE;
      ST_FRM_RD:     state_nxt = ST_FRM_EMIT;
      ST_FRM_EMIT:   if (emit) state_nxt = e_end ? ST_IDLE : ST_FRM_RD;
      ST_RES_RD:     state_nxt = ST_RES_EMIT;
      ST_RES_EMIT:   if (emit) state_nxt = e_end ? ST_IDLE : ST_RES_RD;
      ST_ERR:        if (emit) state_nxt = ST_TOK_SEND;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // result and memory-write outputs
  always_comb begin
    emit      = 1'b0;
    e_target  = TGT_PHY;
    e_byte    = '0;
    e_kind    = 1'b0;
    e_station = '0;
    e_end     = 1'b0;
    fq_we     = 1'b0;
    fq_wa     = wr_base_r;
    fq_wd     = wr_h0_r;
    case (state_r)
      ST_NEW_TOKEN: begin
        emit  = out_free;
        e_end = (idx_r == IW'(STATIONS));
        if (idx_r == '0) e_byte = cfg.tag;
        else if ((idx_r - IW'(1)) == IW'(cfg.own)) e_byte = both;
      end
      ST_MSG_WR: begin
        fq_we = 1'b1;
        if (wr_mask_r[MW_H0]) begin
          fq_wa = wr_base_r;
          fq_wd = wr_h0_r;
        end else if (wr_mask_r[MW_H1]) begin
          fq_wa = wr_base_r + FAW'(1);
          fq_wd = wr_h1_r;
        end else if (wr_mask_r[MW_PAY]) begin
          fq_wa = wr_base_r + FAW'(3) + FAW'(wr_pcnt_r);
          fq_wd = wr_data_r;
        end else if (wr_mask_r[MW_LEN]) begin
          fq_wa = wr_base_r + FAW'(2);
          fq_wd = 8'(wr_cnt_r);
        end else begin
          fq_wa = wr_base_r + FAW'(3) + FAW'(wr_cnt_r);
          fq_wd = wr_stat_r;
        end
      end
      ST_TOK_CHG: begin
        emit     = out_free;
        e_target = TGT_LIST;
      end
      ST_TOK_SEND: begin
        emit   = out_free;
        e_byte = held_r[TIW'(idx_r)];
        e_end  = (idx_r == IW'(TLEN - 1));
      end
      ST_FRM_EMIT: begin
        emit   = out_free;
        e_byte = fq_rd_r;
        e_end  = (idx_r == frame_last);
      end
      ST_RES_EMIT: begin
        emit   = out_free;
        e_byte = sent_rd_r;
        e_end  = (idx_r == frame_last);
      end
      ST_ERR: begin
        emit      = out_free;
        e_target  = TGT_ERR;
        e_kind    = err_kind_r;
        e_station = sent_dst_r;
      end
      default: emit = 1'b0;
    endcase
  end

  // frame queue memory
  always_ff @(posedge clk) begin
    if (fq_we) fq_mem[fq_wa] <= fq_wd;
    if (state_r == ST_FRM_RD) fq_rd_r <= fq_mem[rd_base_r + FAW'(idx_r)];
  end

  // copy of the frame on the ring, for resends
  always_ff @(posedge clk) begin
    if (state_r == ST_FRM_EMIT && emit) sent_mem[SAW'(idx_r)] <= fq_rd_r;
    if (state_r == ST_RES_RD) sent_rd_r <= sent_mem[SAW'(idx_r)];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_MSG) begin
      wr_base_r <= tail_base;
      wr_h0_r   <= h0;
      wr_h1_r   <= h1;
      wr_data_r <= cmd.data;
      wr_pcnt_r <= b_count_r;
      wr_cnt_r  <= cnt1;
      wr_stat_r <= {stat_sum, 2'b00};
      if (cmd.last && !drop) qlen_r[tail_idx] <= LW'(cnt1) + LW'(4);
    end
    if (cmd_pop && cmd.op == OP_STATUS) begin
      err_kind_r <= cmd.data[1] ? ERR_CHECKSUM : ERR_NO_ANSWER;
    end
    if (cmd_pop && cmd.op == OP_TOKEN && !tok_held_r && tc_ok) begin
      held_r[TIW'(tok_cnt_r)] <= cmd.data;
    end
    if (state_r == ST_TOK_ZERO && idx_r < IW'(TLEN)) held_r[TIW'(idx_r)] <= '0;
    if (state_r == ST_TOK_OWN && cfg.own < 4'(STATIONS)) begin
      held_r[TIW'({1'b0, cfg.own} + 5'd1)] <= conn_r ? both : time_only;
    end
    if (state_r == ST_TOK_DECIDE && q_count_r != '0) begin
      rd_base_r  <= FAW'(32'(q_head_r) * MAX_FRAME);
      sent_len_r <= qlen_r[q_head_r];
    end
    if (state_r == ST_FRM_EMIT && emit && idx_r == IW'(1)) sent_dst_r <= fq_rd_r[6:3];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      q_head_r   <= '0;
      q_count_r  <= '0;
      b_count_r  <= '0;
      b_sum_r    <= '0;
      b_drop_r   <= 1'b0;
      wr_mask_r  <= '0;
      tok_cnt_r  <= '0;
      tok_held_r <= 1'b0;
      conn_r     <= 1'b0;
      chg_r      <= 1'b0;
      retry_r    <= '0;
      for (int i = 0; i < STATIONS; i++) known_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_NEW_TOKEN: begin
                idx_r   <= '0;
                chg_r   <= 1'b0;
                conn_r  <= 1'b1;
                retry_r <= '0;
                for (int i = 0; i < STATIONS; i++) begin
                  if (4'(i) != cfg.own) known_r[i] <= '0;
                end
              end
              OP_START: conn_r <= 1'b1;
              OP_STOP:  conn_r <= 1'b0;
              OP_MSG: begin
                wr_mask_r <= mask;
                if (cmd.last) begin
                  b_count_r <= '0;
                  b_sum_r   <= '0;
                  b_drop_r  <= 1'b0;
                  if (!drop) q_count_r <= q_count_r + QCW'(1);
                end else begin
                  b_count_r <= cnt1;
                  b_sum_r   <= s1;
                  b_drop_r  <= drop;
                end
              end
              OP_TOKEN: begin
                if (!tok_held_r) begin
                  if (cmd.last) begin
                    tok_cnt_r <= '0;
                    idx_r     <= IW'(tcnt1);
                  end else begin
                    tok_cnt_r <= tcnt1;
                  end
                end
              end
              OP_STATUS: begin
                idx_r <= '0;
                if (tok_held_r) begin
                  if (cmd.data[1:0] == 2'b11) retry_r <= '0;
                  else if (cmd.data[1] && retry_ok) retry_r <= retry_r + RW'(1);
                  else retry_r <= '0;
                end
              end
              default: idx_r <= idx_r;
            endcase
          end
        end
        ST_NEW_TOKEN: if (emit) idx_r <= idx_r + IW'(1);
        ST_MSG_WR:    wr_mask_r <= mask_rest;
        ST_TOK_ZERO:  if (idx_r < IW'(TLEN)) idx_r <= idx_r + IW'(1);
        ST_TOK_DECIDE: begin
          idx_r <= '0;
          if (q_count_r != '0) begin
            q_head_r   <= (32'(q_head_r) == QUEUE_DEPTH - 1) ? '0 : q_head_r + QAW'(1);
            q_count_r  <= q_count_r - QCW'(1);
            tok_held_r <= 1'b1;
          end
        end
        ST_TOK_CMP: begin
          // take in any entry that differs from the known list
          if (cmp_diff) begin
            known_r[st_idx] <= held_r[TIW'(idx_r + IW'(1))];
            chg_r <= 1'b1;
          end
          idx_r <= (idx_r == IW'(STATIONS - 1)) ? '0 : idx_r + IW'(1);
        end
        ST_TOK_CHG: if (emit) chg_r <= 1'b0;
        ST_TOK_SEND: begin
          if (emit) begin
            idx_r <= idx_r + IW'(1);
            if (e_end) tok_held_r <= 1'b0;
          end
        end
        ST_FRM_EMIT: if (emit) idx_r <= idx_r + IW'(1);
        ST_RES_EMIT: if (emit) idx_r <= idx_r + IW'(1);
        default: idx_r <= idx_r;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_target_r  <= e_target;
      out_byte_r    <= e_byte;
      out_kind_r    <= e_kind;
      out_station_r <= e_station;
      out_end_r     <= e_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target        = out_target_r;
  assign out_out_byte      = out_byte_r;
  assign out_error_kind    = out_kind_r;
  assign out_error_station = out_station_r;
  assign out_end_of_run    = out_end_r;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCW'(QUEUE_DEPTH))
    else $error("frame queue count beyond depth");

  a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r <= RW'(MAX_RETRIES))
    else $error("retry count beyond limit");

  a_token_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOK_SEND && emit && e_end) |=> !tok_held_r)
    else $error("token still held after it was sent");

  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FRM_EMIT && emit && e_end) |=> (tok_held_r && state_r == ST_IDLE))
    else $error("token not held after frame send");

endmodule

// File: tb/trms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trms_checker
// Watches the configuration port and both channels of the token-ring MAC
// sender, predicts every result from the accepted transactions and compares
// each accepted result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module trms_checker
  import trms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [3:0] in_dest_station,
  input  logic [2:0] in_dest_service,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_target,
  input  logic [7:0] out_out_byte,
  input  logic       out_error_kind,
  input  logic [3:0] out_error_station,
  input  logic       out_end_of_run,
  output int         fails,
  output int         pending
);

  localparam int STATIONS    = 15;
  localparam int MAX_FRAME   = 50;
  localparam int QUEUE_DEPTH = 3;
  localparam int MAX_RETRIES = 3;
  localparam int TOKEN_LEN   = STATIONS + 1;
  localparam int MAX_PAYLOAD = MAX_FRAME - 4;

  typedef struct {
    logic [1:0] target;
    logic [7:0] data;
    logic       kind;
    logic [3:0] station;
    logic       eor;
  } mac_result_t;

  mac_result_t tx_expected[$];

  // configuration copy
  logic [3:0] own_addr;
  logic [7:0] tag_val;
  logic [2:0] time_sap, chat_sap;
  logic [3:0] bcast_addr;

  // sender state copy
  logic [7:0] frame_mem [QUEUE_DEPTH*MAX_FRAME];
  int         frame_len [QUEUE_DEPTH];
  int         q_head, q_count;
  int         bld_count, bld_sum;
  bit         bld_drop;
  logic [7:0] last_frame [MAX_FRAME];
  int         last_len;
  logic [7:0] token_buf [TOKEN_LEN];
  int         tok_count;
  bit         tok_held;
  logic [7:0] known_copy [STATIONS];
  bit         is_connected, list_dirty;
  int         retries;

  assign pending = tx_expected.size();

  task automatic push_result(logic [1:0] t, logic [7:0] d, logic k, logic [3:0] s);
    mac_result_t r;
    r.target = t; r.data = d; r.kind = k; r.station = s; r.eor = 1'b0;
    tx_expected.push_back(r);
  endtask

  task automatic forward_token();
    for (int i = 0; i < TOKEN_LEN; i++) push_result(TGT_PHY, token_buf[i], 1'b0, 4'd0);
    tok_held = 1'b0;
  endtask

  task automatic flag_error(logic kind);
    push_result(TGT_ERR, 8'd0, kind, last_frame[1][6:3]);
    retries = 0;
    forward_token();
  endtask

  task automatic predict_tx(logic [2:0] act, logic [3:0] dst, logic [2:0] dsap,
                            logic [7:0] b, logic last);
    logic [7:0] both, h0, h1;
    logic [2:0] ssap;
    int         n0, tail, base, len, s;
    both = (8'd1 << time_sap) | (8'd1 << chat_sap);
    n0 = tx_expected.size();
    case (act)
      ACT_NEW_TOKEN: begin
        push_result(TGT_PHY, tag_val, 1'b0, 4'd0);
        for (int i = 0; i < STATIONS; i++) begin
          if (i == own_addr) begin
            push_result(TGT_PHY, both, 1'b0, 4'd0);
          end else begin
            known_copy[i] = 8'd0;
            push_result(TGT_PHY, 8'd0, 1'b0, 4'd0);
          end
        end
        list_dirty = 1'b0;
        is_connected = 1'b1;
        retries = 0;
      end
      ACT_START: is_connected = 1'b1;
      ACT_STOP:  is_connected = 1'b0;
      ACT_MSG_BYTE: begin
        tail = (q_head + q_count) % QUEUE_DEPTH;
        base = tail * MAX_FRAME;
        if (bld_count == 0) begin
          ssap = (dst == bcast_addr) ? time_sap : chat_sap;
          h0 = (own_addr << 3) + ssap;
          h1 = (dst << 3) + dsap;
          bld_drop = q_count >= QUEUE_DEPTH;
          if (!bld_drop) begin
            frame_mem[base] = h0;
            frame_mem[base+1] = h1;
          end
          bld_sum = (h0 + h1) & 63;
        end
        if (bld_count < MAX_PAYLOAD) begin
          if (!bld_drop) frame_mem[base+3+bld_count] = b;
          bld_sum = (bld_sum + b) & 63;
          bld_count++;
        end
        if (last) begin
          if (!bld_drop) begin
            s = (bld_sum + bld_count) & 63;
            frame_mem[base+2] = 8'(bld_count);
            frame_mem[base+3+bld_count] = 8'((s << 2) & 255);
            frame_len[tail] = bld_count + 4;
            q_count++;
          end
          bld_count = 0; bld_sum = 0; bld_drop = 1'b0;
        end
      end
      ACT_TOKEN_BYTE: begin
        if (!tok_held) begin
          if (tok_count < TOKEN_LEN) begin
            token_buf[tok_count] = b;
            tok_count++;
          end
          if (last) begin
            for (int i = tok_count; i < TOKEN_LEN; i++) token_buf[i] = 8'd0;
            tok_count = 0;
            if (q_count > 0) begin
              len = frame_len[q_head];
              base = q_head * MAX_FRAME;
              if (len > MAX_FRAME) len = MAX_FRAME;
              for (int i = 0; i < len; i++) begin
                last_frame[i] = frame_mem[base+i];
                push_result(TGT_PHY, last_frame[i], 1'b0, 4'd0);
              end
              last_len = len;
              q_head = (q_head + 1) % QUEUE_DEPTH;
              q_count--;
              tok_held = 1'b1;
            end else begin
              if (own_addr < STATIONS)
                token_buf[1+own_addr] = is_connected ? both : (8'd1 << time_sap);
              for (int i = 0; i < STATIONS; i++) begin
                if (known_copy[i] != token_buf[1+i]) begin
                  known_copy[i] = token_buf[1+i];
                  list_dirty = 1'b1;
                end
              end
              if (list_dirty) begin
                push_result(TGT_LIST, 8'd0, 1'b0, 4'd0);
                list_dirty = 1'b0;
              end
              forward_token();
            end
          end
        end
      end
      ACT_STATUS: begin
        if (tok_held) begin
          if (b[1:0] == 2'b11) begin
            retries = 0;
            forward_token();
          end else if (b[1]) begin
            if (retries < MAX_RETRIES) begin
              retries++;
              for (int i = 0; i < last_len; i++)
                push_result(TGT_PHY, last_frame[i], 1'b0, 4'd0);
            end else begin
              flag_error(ERR_CHECKSUM);
            end
          end else begin
            flag_error(ERR_NO_ANSWER);
          end
        end
      end
      default: ;
    endcase
    if (tx_expected.size() > n0) tx_expected[tx_expected.size()-1].eor = 1'b1;
  endtask

  always @(posedge clk) begin
    mac_result_t e;
    if (!rst_n) begin
      own_addr <= 4'd0; tag_val <= 8'd255; time_sap <= 3'd1; chat_sap <= 3'd3;
      bcast_addr <= 4'd15;
      q_head = 0; q_count = 0; bld_count = 0; bld_sum = 0; bld_drop = 1'b0;
      last_len = 0; tok_count = 0; tok_held = 1'b0;
      for (int i = 0; i < STATIONS; i++) known_copy[i] = 8'd0;
      is_connected = 1'b0; list_dirty = 1'b0; retries = 0;
      tx_expected.delete();
      fails <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tx_expected.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10)
            $display("ERROR: unexpected result target=%0d byte=%02h kind=%0d stn=%0d eor=%0d",
                     out_target, out_out_byte, out_error_kind, out_error_station,
                     out_end_of_run);
        end else begin
          e = tx_expected.pop_front();
          if (out_target !== e.target || out_out_byte !== e.data ||
              out_error_kind !== e.kind || out_error_station !== e.station ||
              out_end_of_run !== e.eor) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("ERROR: exp tgt=%0d byte=%02h kind=%0d stn=%0d eor=%0d got tgt=%0d byte=%02h kind=%0d stn=%0d eor=%0d",
                       e.target, e.data, e.kind, e.station, e.eor, out_target,
                       out_out_byte, out_error_kind, out_error_station, out_end_of_run);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_tx(in_action, in_dest_station, in_dest_service, in_data_byte, in_last_byte);
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDRESS:       own_addr   <= cfg_wdata[3:0];
          CFG_TOKEN_TAG_VALUE:   tag_val    <= cfg_wdata;
          CFG_TIME_SERVICE:      time_sap   <= cfg_wdata[2:0];
          CFG_CHAT_SERVICE:      chat_sap   <= cfg_wdata[2:0];
          CFG_BROADCAST_STATION: bcast_addr <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the token-ring MAC sender: directed framing, token and status
// cases, then random frame/token/status sequences under several register
// settings, with bursty input, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import trms_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 2500;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_action = '0;
  logic [3:0] in_dest_station = '0;
  logic [2:0] in_dest_service = '0;
  logic [7:0] in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_target;
  logic [7:0] out_out_byte;
  logic       out_error_kind;
  logic [3:0] out_error_station;
  logic       out_end_of_run;
  int         fails, pending;

  int         cyc = 0;
  int         burst_left = 0;
  int         sent_items = 0;
  bit         hold_go = 1'b0;
  logic [7:0] prev_token [16];

  always #5 clk = ~clk;

  token_ring_mac_sender_core dut (.*);

  trms_checker chk (.*);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off
  initial begin
    int mode, hold_cnt;
    bit hold_done;
    hold_cnt = 0; hold_done = 1'b0; mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  task automatic send_tx(logic [2:0] a, logic [3:0] dst, logic [2:0] dsap,
                         logic [7:0] b, logic last);
    int g;
    if (burst_left == 0) begin
      g = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= a; in_dest_station <= dst; in_dest_service <= dsap;
    in_data_byte <= b; in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic send_msg(int len);
    logic [3:0] dst;
    dst = ($urandom_range(0, 3) == 0) ? chk.bcast_addr : 4'($urandom);
    for (int i = 0; i < len; i++)
      send_tx(ACT_MSG_BYTE, (i == 0) ? dst : 4'($urandom), 3'($urandom), 8'($urandom),
              i == len - 1);
  endtask

  task automatic send_token(int len, bit repeat_prev);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (repeat_prev && i < 16) b = prev_token[i];
      else if ($urandom_range(0, 2) == 0) b = 8'd0;
      else b = 8'($urandom);
      if (i < 16) prev_token[i] = b;
      send_tx(ACT_TOKEN_BYTE, 4'($urandom), 3'($urandom), b, i == len - 1);
    end
  endtask

  task automatic send_status(logic [1:0] code);
    send_tx(ACT_STATUS, 4'($urandom), 3'($urandom), {6'($urandom), code}, 1'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(int n_items);
    int stop_at, pick;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // frames then a token, then returned status
        repeat ($urandom_range(1, 4))
          send_msg(($urandom_range(0, 15) == 0) ? $urandom_range(44, 52) : $urandom_range(1, 6));
        send_token(($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 16, 1'b0);
        repeat ($urandom_range(0, 5)) send_status(2'($urandom));
      end else if (pick < 60) begin
        send_token(($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 16,
                   $urandom_range(0, 2) == 0);
      end else if (pick < 68) begin
        send_tx(ACT_NEW_TOKEN, 4'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 76) begin
        send_tx($urandom_range(0, 1) ? ACT_START : ACT_STOP, 4'($urandom), 3'($urandom),
                8'($urandom), 1'($urandom));
      end else if (pick < 84) begin
        send_status(2'($urandom));
      end else begin
        send_tx(3'($urandom), 4'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) prev_token[i] = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: control actions, unknown actions, framing, retries and errors
    burst_left = 100;
    send_tx(ACT_NEW_TOKEN, 4'd0, 3'd0, 8'd0, 1'b0);
    send_tx(ACT_STOP, 4'd0, 3'd0, 8'd0, 1'b0);
    send_tx(ACT_START, 4'd0, 3'd0, 8'd0, 1'b0);
    send_tx(3'd6, 4'hF, 3'd7, 8'hFF, 1'b1);
    send_tx(3'd7, 4'hF, 3'd7, 8'hFF, 1'b1);
    send_status(2'b11);                                  // status with no token held
    send_tx(ACT_MSG_BYTE, 4'hF, 3'd7, 8'hFF, 1'b0);
    send_tx(ACT_MSG_BYTE, 4'd0, 3'd0, 8'h00, 1'b1);
    send_tx(ACT_TOKEN_BYTE, 4'd0, 3'd0, 8'hA5, 1'b0);      // short token sends the frame
    send_tx(ACT_TOKEN_BYTE, 4'd0, 3'd0, 8'h3C, 1'b1);
    send_tx(ACT_TOKEN_BYTE, 4'd0, 3'd0, 8'h11, 1'b1);      // ignored while held
    send_status(2'b10);
    send_status(2'b10);
    send_status(2'b10);
    send_status(2'b10);                                  // retries exhausted
    send_tx(ACT_MSG_BYTE, 4'd0, 3'd0, 8'h80, 1'b1);
    send_tx(ACT_TOKEN_BYTE, 4'd0, 3'd0, 8'h01, 1'b1);
    send_status(2'b01);                                  // no answer
    settle();

    random_traffic(100);
    settle();

    // extremes: high own address, zero tag, equal services
    write_reg(CFG_OWN_ADDRESS, 8'd14);
    write_reg(CFG_TOKEN_TAG_VALUE, 8'd0);
    write_reg(CFG_TIME_SERVICE, 8'd7);
    write_reg(CFG_CHAT_SERVICE, 8'd7);
    write_reg(CFG_BROADCAST_STATION, 8'd0);
    hold_go = 1'b1;
    random_traffic(100);
    settle();

    // own address outside the station list
    write_reg(CFG_OWN_ADDRESS, 8'd15);
    write_reg(CFG_TOKEN_TAG_VALUE, 8'd255);
    write_reg(CFG_TIME_SERVICE, 8'd0);
    write_reg(CFG_CHAT_SERVICE, 8'd0);
    write_reg(CFG_BROADCAST_STATION, 8'd15);
    random_traffic(60);
    settle();

    write_reg(CFG_OWN_ADDRESS, 8'($urandom_range(0, 14)));
    write_reg(CFG_TOKEN_TAG_VALUE, 8'($urandom));
    write_reg(CFG_TIME_SERVICE, 8'($urandom_range(0, 7)));
    write_reg(CFG_CHAT_SERVICE, 8'($urandom_range(0, 7)));
    write_reg(CFG_BROADCAST_STATION, 8'($urandom_range(0, 15)));
    random_traffic(120);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/trms_pkg.sv
rtl/trms_front.sv
rtl/trms_back.sv
rtl/token_ring_mac_sender_core.sv
tb/trms_checker.sv
tb/tb.sv
